// ----- rtl/dsks_pkg.sv -----
// ----------------------------------------------------------------------------
// dsks_pkg
// Shared constants and controller/datapath interface types for the digit-sum
// key sorter.
// ----------------------------------------------------------------------------
package dsks_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int VALUE_W       = 31;
	localparam int SUM_W         = 7;
	localparam int RADIX         = 10;
	// floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for any 32-bit v
	localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef struct packed {
		logic capture;      // latch input transfer, clear digit sum
		logic mul_en;       // register quotient of current value by ten
		logic acc_en;       // add remainder digit, advance to quotient
		logic ins_init;     // start insertion at fill position
		logic shift_en;     // move entry one place toward the end
		logic place_en;     // write new entry, bump fill count
		logic drain_rd;     // read entry at drain position
		logic emit_load;    // load output register, advance drain
	} cmd_t;

	typedef struct packed {
		logic digits_done;
		logic full;
		logic empty;
		logic goes_first;
		logic pos_is_one;
		logic last_in;
		logic last_entry;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/dsks_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsks_ctrl
// Sequencer for digit summation, insertion and drain of the sorted store.
// ----------------------------------------------------------------------------
module dsks_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  dsks_pkg::sts_t sts,
	output dsks_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL   = 8'b0000_0010,
		ST_ACC   = 8'b0000_0100,
		ST_INS   = 8'b0000_1000,
		ST_SHIFT = 8'b0001_0000,
		ST_PLACE = 8'b0010_0000,
		ST_RD    = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   draining_q, draining_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d    = state_q;
		draining_d = draining_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (draining_q) begin
						cmd.drain_rd = 1'b1;
						state_d      = ST_EMIT;
					end else begin
						cmd.capture = 1'b1;
						state_d     = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = sts.digits_done ? ST_INS : ST_MUL;
			end
			ST_INS: begin
				cmd.ins_init = 1'b1;
				if (sts.full) begin
					draining_d = sts.last_in;
					state_d    = sts.last_in ? ST_RD : ST_IDLE;
				end else if (sts.empty) begin
					state_d = ST_PLACE;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (sts.goes_first) begin
					cmd.shift_en = 1'b1;
					if (sts.pos_is_one) begin
						state_d = ST_PLACE;
					end
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.place_en = 1'b1;
				draining_d   = sts.last_in;
				state_d      = sts.last_in ? ST_RD : ST_IDLE;
			end
			ST_RD: begin
				cmd.drain_rd = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.last_entry) begin
						draining_d = 1'b0;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d    = ST_IDLE;
				draining_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			draining_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			draining_q <= draining_d;
		end
	end

endmodule

// ----- rtl/dsks_datapath.sv -----
// ----------------------------------------------------------------------------
// dsks_datapath
// Digit-sum unit, sorted entry store with single write / registered read,
// counters and output register.
// ----------------------------------------------------------------------------
module dsks_datapath #(
	parameter int MAX_ITEMS = dsks_pkg::MAX_ITEMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dsks_pkg::VALUE_W-1:0]  value,
	input  logic                          final_item,
	input  dsks_pkg::cmd_t                cmd,
	output dsks_pkg::sts_t                sts,
	output logic [dsks_pkg::VALUE_W-1:0]  sorted_value,
	output logic [dsks_pkg::SUM_W-1:0]    digit_total,
	output logic                          overflowed,
	output logic                          end_of_run,
	output logic                          out_valid,
	input  logic                          out_stall
);

	localparam int VW = dsks_pkg::VALUE_W;
	localparam int SW = dsks_pkg::SUM_W;
	localparam int EW = VW + SW;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int QW = 64 - dsks_pkg::RECIP_SHIFT;

	// digit-sum unit
	logic [VW-1:0] new_val_q;
	logic [VW-1:0] cur_q;
	logic [QW-1:0] quot_q;
	logic [SW-1:0] new_sum_q;
	logic          last_in_q;
	logic [63:0]   prod;
	logic [VW-1:0] quot_ext;
	logic [VW-1:0] rem_full;

	assign prod     = {1'b0, cur_q} * dsks_pkg::RECIP_10;
	assign quot_ext = VW'(quot_q);
	assign rem_full = cur_q - ((quot_ext << 3) + (quot_ext << 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			new_val_q <= value;
			cur_q     <= value;
			last_in_q <= final_item;
			new_sum_q <= '0;
		end
		if (cmd.mul_en) begin
			quot_q <= prod[63:dsks_pkg::RECIP_SHIFT];
		end
		if (cmd.acc_en) begin
			new_sum_q <= new_sum_q + SW'(rem_full[3:0]);
			cur_q     <= quot_ext;
		end
	end

	// sorted store
	logic [EW-1:0] mem [MAX_ITEMS];
	logic [EW-1:0] rd_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] drain_pos_q;
	logic          drop_q;
	logic          rd_en;
	logic [CW-1:0] rd_addr;
	logic          wr_en;
	logic [EW-1:0] wr_data;
	logic          full;
	logic          empty;
	logic          last_entry;
	logic [VW-1:0] rd_val;
	logic [SW-1:0] rd_sum;

	assign full       = (fill_q == CW'(MAX_ITEMS));
	assign empty      = (fill_q == '0);
	assign last_entry = ((drain_pos_q + CW'(1)) >= fill_q);
	assign rd_val     = rd_q[VW-1:0];
	assign rd_sum     = rd_q[EW-1:VW];

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = drain_pos_q;
		if (cmd.ins_init) begin
			rd_en   = !empty;
			rd_addr = fill_q - CW'(1);
		end else if (cmd.shift_en) begin
			rd_en   = (pos_q != CW'(1));
			rd_addr = pos_q - CW'(2);
		end else if (cmd.drain_rd) begin
			rd_en   = 1'b1;
			rd_addr = drain_pos_q;
		end
	end

	assign wr_en   = cmd.shift_en || cmd.place_en;
	assign wr_data = cmd.shift_en ? rd_q : {new_sum_q, new_val_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pos_q       <= '0;
			drain_pos_q <= '0;
			drop_q      <= 1'b0;
		end else begin
			if (cmd.ins_init) begin
				pos_q <= fill_q;
				if (full) begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.shift_en) begin
				pos_q <= pos_q - CW'(1);
			end
			if (cmd.place_en) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.emit_load) begin
				if (last_entry) begin
					fill_q      <= '0;
					drain_pos_q <= '0;
					drop_q      <= 1'b0;
				end else begin
					drain_pos_q <= drain_pos_q + CW'(1);
				end
			end
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			sorted_value <= rd_val;
			digit_total  <= rd_sum;
			overflowed   <= drop_q;
			end_of_run   <= last_entry;
		end
	end

	assign out_valid = out_valid_q;

	// status
	always_comb begin
		sts             = '0;
		sts.digits_done = (quot_q == '0);
		sts.full        = full;
		sts.empty       = empty;
		sts.goes_first  = (new_sum_q != rd_sum) ? (new_sum_q > rd_sum) : (new_val_q < rd_val);
		sts.pos_is_one  = (pos_q == CW'(1));
		sts.last_in     = last_in_q;
		sts.last_entry  = last_entry;
		sts.out_free    = !out_valid_q || !out_stall;
	end

endmodule

// ----- rtl/digit_sum_key_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// digit_sum_key_sorter_unit
// Loads a set of values, keeps them ordered by descending decimal digit sum
// (ties by ascending value) and drains them one result per transfer.
// ----------------------------------------------------------------------------
// A loading transfer runs the divide-by-ten multiply and accumulate loop once
// per decimal digit of the value (1 to 10 digits), sets up the insertion,
// moves aside each stored entry that is to follow it, one at a time (the
// store has one write port) and places the new entry. The transfer flagged
// final_item then returns the first result; every further input transfer
// during the drain is ignored and returns the next result: the entry is
// read, then the output register is loaded once it is no longer held. The
// last result carries end_of_run; the store then starts empty. Values beyond
// MAX_ITEMS are dropped and overflowed is set on every result of that run.
// ----------------------------------------------------------------------------
module digit_sum_key_sorter_unit #(
	parameter int MAX_ITEMS = dsks_pkg::MAX_ITEMS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dsks_pkg::VALUE_W-1:0] value,
	input  logic                         final_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [dsks_pkg::VALUE_W-1:0] sorted_value,
	output logic [dsks_pkg::SUM_W-1:0]   digit_total,
	output logic                         overflowed,
	output logic                         end_of_run
);

	dsks_pkg::cmd_t cmd;
	dsks_pkg::sts_t sts;

	dsks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsks_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.final_item   (final_item),
		.cmd          (cmd),
		.sts          (sts),
		.sorted_value (sorted_value),
		.digit_total  (digit_total),
		.overflowed   (overflowed),
		.end_of_run   (end_of_run),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

endmodule

// ----- rtl/dsks_checker.sv -----
// ----------------------------------------------------------------------------
// dsks_checker
// Port-level checks for the digit-sum key sorter, bound to the top level.
// ----------------------------------------------------------------------------
module dsks_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [dsks_pkg::VALUE_W-1:0] sorted_value,
	input logic [dsks_pkg::SUM_W-1:0]   digit_total,
	input logic                         end_of_run
);

	localparam logic [dsks_pkg::SUM_W-1:0] MAX_SUM = dsks_pkg::SUM_W'(90);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(end_of_run))
		else $error("stalled result changed");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_total <= MAX_SUM)
		else $error("digit total out of range");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

endmodule

bind digit_sum_key_sorter_unit dsks_checker u_dsks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sorted_value (sorted_value),
	.digit_total  (digit_total),
	.end_of_run   (end_of_run)
);
